// ===== rtl/uap_pkg.sv =====
package uap_pkg;

   // Longest URL that is parsed before it is cut off with an error.
   localparam int MAX_URL_LEN = 256;
   localparam int LEN_W       = $clog2(MAX_URL_LEN + 1);

   typedef enum logic [1:0] {
      PH_SCHEME,
      PH_IPV4,
      PH_HOST,
      PH_PORT
   } phase_type;

   typedef struct packed {
      logic [7:0] url_char;
      logic       start_of_url;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic        address_kind;
      logic [31:0] ip_address;
      logic [15:0] port;
      logic [7:0]  host_offset;
      logic [7:0]  host_length;
   } rsp_item_type;

   // One character after classification.
   typedef struct packed {
      logic       start;
      logic       is_digit;
      logic       is_alnum;
      logic       is_host_sym;
      logic       is_dot;
      logic       is_colon;
      logic       is_slash;
      logic       is_nul;
      logic       is_lbracket;
      logic [3:0] digit;
   } cls_item_type;

   typedef struct packed {
      logic         valid;
      cls_item_type item;
   } cls_chan_type;

endpackage

// ===== rtl/url_authority_parser.sv =====
// Channel    Ports                        Direction  Item
// request    push, full, req_item         in         one URL character and a start flag
// response   empty, pop, rsp_item         out        one parse result per finished URL
//
// The block takes one character every cycle while the response side keeps up.
// A character accepted into the front queue is parsed when it heads that queue and the
// result queue has room; any result it yields is registered into the result queue.
// Reset is synchronous and active high; the parser then idles until a start_of_url item.
// Two-entry queues before and after the parser let each side stall on its own, and full
// rises only when the parser has stopped for a full result queue.
module url_authority_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  uap_pkg::req_item_type req_item,
   output logic                  empty,
   input  logic                  pop,
   output uap_pkg::rsp_item_type rsp_item
);
   import uap_pkg::*;

   cls_chan_type cls_head;
   logic         cls_take;

   // The front end classifies each character (digit, alphanumeric, separators) and
   // holds it in a short queue so that the parser sees only a few decoded flags.
   uap_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cls_head (cls_head),
      .cls_take (cls_take)
   );

   // While its result queue has room, the back end walks scheme, IPv4, hostname and port
   // phases one character per cycle, and queues a result as each URL succeeds or fails.
   uap_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cls_head (cls_head),
      .cls_take (cls_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/uap_front.sv =====
module uap_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  uap_pkg::req_item_type req_item,
   output uap_pkg::cls_chan_type cls_head,
   input  logic                  cls_take
);
   import uap_pkg::*;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_DASH       = 8'h2d;
   localparam logic [7:0] CH_DOT        = 8'h2e;
   localparam logic [7:0] CH_SLASH      = 8'h2f;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_COLON      = 8'h3a;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CH_LBRACKET   = 8'h5b;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7a;

   cls_item_type cls_new;
   cls_item_type head_ff, head_in, spare_ff, spare_in;
   logic         head_v_ff, head_v_in, spare_v_ff, spare_v_in;
   logic         push_ok, pop_ok;

   always_comb begin
      logic [7:0] c;
      c = req_item.url_char;
      cls_new.start       = req_item.start_of_url;
      cls_new.is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
      cls_new.is_alnum    = cls_new.is_digit || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
                            ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
      cls_new.is_host_sym = (c == CH_UNDERSCORE) || (c == CH_DASH);
      cls_new.is_dot      = (c == CH_DOT);
      cls_new.is_colon    = (c == CH_COLON);
      cls_new.is_slash    = (c == CH_SLASH);
      cls_new.is_nul      = (c == CH_NUL);
      cls_new.is_lbracket = (c == CH_LBRACKET);
      cls_new.digit       = c[3:0];
   end

   assign full    = spare_v_ff;
   assign push_ok = push && !spare_v_ff;
   assign pop_ok  = head_v_ff && cls_take;

   // Two-entry queue: a head that the parser sees and a spare behind it.
   always_comb begin
      head_in    = head_ff;
      head_v_in  = head_v_ff;
      spare_in   = spare_ff;
      spare_v_in = spare_v_ff;
      if (pop_ok) begin
         if (spare_v_ff) begin
            head_in    = spare_ff;
            head_v_in  = 1'b1;
            spare_in   = cls_new;
            spare_v_in = push_ok;
         end else begin
            head_in   = cls_new;
            head_v_in = push_ok;
         end
      end else if (!head_v_ff) begin
         head_in   = cls_new;
         head_v_in = push_ok;
      end else if (push_ok) begin
         spare_in   = cls_new;
         spare_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff  <= 1'b0;
         spare_v_ff <= 1'b0;
      end else begin
         head_v_ff  <= head_v_in;
         spare_v_ff <= spare_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign cls_head.valid = head_v_ff;
   assign cls_head.item  = head_ff;

   a_spare_behind_head: assert property (@(posedge clock) disable iff (reset)
      spare_v_ff |-> head_v_ff)
      else $error("front queue holds a spare entry without a head entry");

endmodule

// ===== rtl/uap_back.sv =====
module uap_back (
   input  logic                  clock,
   input  logic                  reset,
   input  uap_pkg::cls_chan_type cls_head,
   output logic                  cls_take,
   output logic                  empty,
   input  logic                  pop,
   output uap_pkg::rsp_item_type rsp_item
);
   import uap_pkg::*;

   phase_type        phase_ff, phase_in;
   logic             active_ff, active_in;
   logic [1:0]       sm_ff, sm_in;
   logic [3:0][7:0]  oct_ff, oct_in;
   logic [1:0]       oi_ff, oi_in;
   logic [2:0]       dot_ff, dot_in;
   logic [2:0]       dc_ff, dc_in;
   logic [15:0]      port_ff, port_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       hs_ff, hs_in;
   logic [7:0]       hc_ff, hc_in;
   logic             rf_ff, rf_in;
   logic [LEN_W-1:0] len_ff, len_in;

   logic             step_emit, step_status;
   logic             go;
   cls_item_type     it;
   rsp_item_type     res_new;
   logic             res_push, res_pop;
   rsp_item_type     out_ff, out_in, spare_ff, spare_in;
   logic             out_v_ff, out_v_in, spare_v_ff, spare_v_in;

   assign it       = cls_head.item;
   assign go       = cls_head.valid && !spare_v_ff;
   assign cls_take = go;

   // Next state of the parser for the character at the head of the queue.
   always_comb begin
      logic       take;
      logic [7:0] p;
      logic [7:0] o;
      logic [7:0] base;
      take = 1'b0;
      p    = 8'd0;
      o    = 8'd0;
      base = 8'd0;
      step_emit   = 1'b0;
      step_status = 1'b0;
      if (it.start) begin
         active_in = 1'b1;
         phase_in  = PH_SCHEME;
         sm_in     = 2'd0;
         oct_in    = '0;
         oi_in     = 2'd0;
         dot_in    = 3'd0;
         dc_in     = 3'd0;
         port_in   = 16'd0;
         pos_in    = 8'd0;
         hs_in     = 8'd0;
         hc_in     = 8'd0;
         rf_in     = 1'b0;
         len_in    = '0;
      end else begin
         active_in = active_ff;
         phase_in  = phase_ff;
         sm_in     = sm_ff;
         oct_in    = oct_ff;
         oi_in     = oi_ff;
         dot_in    = dot_ff;
         dc_in     = dc_ff;
         port_in   = port_ff;
         pos_in    = pos_ff;
         hs_in     = hs_ff;
         hc_in     = hc_ff;
         rf_in     = rf_ff;
         len_in    = len_ff;
      end

      if (active_in) begin
         if (len_in >= LEN_W'(MAX_URL_LEN)) begin
            step_emit   = 1'b1;
            step_status = 1'b1;
         end else begin
            len_in = len_in + LEN_W'(1);
            p      = pos_in;
            pos_in = pos_in + 8'd1;
            take   = 1'b1;

            if (phase_in == PH_SCHEME) begin
               take = 1'b0;
               if (sm_in == 2'd0) begin
                  if (it.is_colon) begin
                     sm_in = 2'd1;
                  end else if (!it.is_alnum) begin
                     step_emit   = 1'b1;
                     step_status = 1'b1;
                  end
               end else if (sm_in != 2'd3) begin
                  if (!it.is_slash) begin
                     step_emit   = 1'b1;
                     step_status = 1'b1;
                  end else begin
                     sm_in = sm_in + 2'd1;
                  end
               end else if (it.is_lbracket) begin
                  step_emit   = 1'b1;
                  step_status = 1'b1;
               end else begin
                  phase_in = PH_IPV4;
                  hs_in    = p;
                  hc_in    = 8'd0;
                  take     = 1'b1;
               end
            end

            if (take && (phase_in == PH_IPV4)) begin
               rf_in = 1'b0;
               if (it.is_digit) begin
                  dc_in = dc_in + 3'd1;
                  if (dc_in >= 3'd4) begin
                     phase_in = PH_HOST;
                  end else begin
                     o    = oct_in[oi_in];
                     base = (dc_in > 3'd1) ? ({o[4:0], 3'b000} + {o[6:0], 1'b0}) : o;
                     oct_in[oi_in] = base + {4'd0, it.digit};
                     hc_in = hc_in + 8'd1;
                     take  = 1'b0;
                  end
               end else if (it.is_dot) begin
                  dot_in = dot_in + 3'd1;
                  if (dot_in >= 3'd4) begin
                     phase_in = PH_HOST;
                  end else begin
                     dc_in = 3'd0;
                     oi_in = oi_in + 2'd1;
                     hc_in = hc_in + 8'd1;
                     take  = 1'b0;
                  end
               end else if (it.is_colon) begin
                  take = 1'b0;
                  if (dot_in != 3'd3) begin
                     step_emit   = 1'b1;
                     step_status = 1'b1;
                  end else begin
                     phase_in = PH_PORT;
                     port_in  = 16'd0;
                     dc_in    = 3'd0;
                  end
               end else begin
                  phase_in = PH_HOST;
               end
            end

            if (take && (phase_in == PH_HOST)) begin
               take  = 1'b0;
               rf_in = 1'b1;
               if (it.is_alnum || it.is_host_sym || it.is_dot) begin
                  hc_in = hc_in + 8'd1;
               end else if (it.is_colon) begin
                  phase_in = PH_PORT;
                  port_in  = 16'd0;
                  dc_in    = 3'd0;
               end else begin
                  step_emit   = 1'b1;
                  step_status = 1'b1;
               end
            end

            if (take && (phase_in == PH_PORT)) begin
               if (it.is_digit) begin
                  port_in = {port_in[12:0], 3'b000} + {port_in[14:0], 1'b0} +
                            {12'd0, it.digit};
                  if (dc_in != 3'd7) begin
                     dc_in = dc_in + 3'd1;
                  end
               end else if ((it.is_nul || it.is_slash) && (dc_in != 3'd0)) begin
                  step_emit = 1'b1;
               end else begin
                  step_emit   = 1'b1;
                  step_status = 1'b1;
               end
            end
         end
         if (step_emit) begin
            active_in = 1'b0;
         end
      end
   end

   // Result item formed from the state as it stands after this character.
   always_comb begin
      res_new.status       = step_status;
      res_new.address_kind = rf_in;
      res_new.ip_address   = {oct_in[0], oct_in[1], oct_in[2], oct_in[3]};
      res_new.port         = port_in;
      res_new.host_offset  = hs_in;
      res_new.host_length  = hc_in;
      res_push             = go && step_emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PH_SCHEME;
         sm_ff     <= 2'd0;
         oi_ff     <= 2'd0;
         dot_ff    <= 3'd0;
         dc_ff     <= 3'd0;
         len_ff    <= '0;
      end else if (go) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         sm_ff     <= sm_in;
         oi_ff     <= oi_in;
         dot_ff    <= dot_in;
         dc_ff     <= dc_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         oct_ff  <= oct_in;
         port_ff <= port_in;
         pos_ff  <= pos_in;
         hs_ff   <= hs_in;
         hc_ff   <= hc_in;
         rf_ff   <= rf_in;
      end
   end

   // Result queue: a visible output register with one spare behind it.
   assign res_pop = out_v_ff && pop;

   always_comb begin
      out_in     = out_ff;
      out_v_in   = out_v_ff;
      spare_in   = spare_ff;
      spare_v_in = spare_v_ff;
      if (res_pop) begin
         if (spare_v_ff) begin
            out_in     = spare_ff;
            out_v_in   = 1'b1;
            spare_in   = res_new;
            spare_v_in = res_push;
         end else begin
            out_in   = res_new;
            out_v_in = res_push;
         end
      end else if (!out_v_ff) begin
         out_in   = res_new;
         out_v_in = res_push;
      end else if (res_push) begin
         spare_in   = res_new;
         spare_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff   <= 1'b0;
         spare_v_ff <= 1'b0;
      end else begin
         out_v_ff   <= out_v_in;
         spare_v_ff <= spare_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign empty    = !out_v_ff;
   assign rsp_item = out_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !spare_v_ff)
      else $error("result written while the result queue is full");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !active_ff)
      else $error("parser still active after giving its result");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_URL_LEN))
      else $error("URL length counter ran past its limit");

   a_dots_bounded: assert property (@(posedge clock) disable iff (reset)
      dot_ff <= 3'd4)
      else $error("dot count ran past four");

endmodule
